// ----- hw/rtl/rrd_pkg.sv -----
// rrd_pkg: shared types and constants for the round-robin request dispatcher.
// Holds the transfer payload structs, operation/result codes and the FSM state type.
// No dependencies.
package rrd_pkg;

  localparam int NUM_SERVERS_DEF = 16;
  localparam int ID_W            = 6;
  localparam int TIME_W          = 32;
  localparam int WORK_W          = 48;
  localparam int END_W           = TIME_W + 1;

  typedef enum logic [0:0] {
    OP_REQUEST = 1'b0,
    OP_REPORT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_DROPPED  = 2'd1,
    KIND_REPORT   = 2'd2
  } kind_t;

  typedef struct packed {
    op_t                operation;
    logic [TIME_W-1:0]  arrival_time;
    logic [TIME_W-1:0]  duration;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    server_id;
    logic [WORK_W-1:0]  work_amount;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_FREE_END,
    ST_PICK,
    ST_UPDATE,
    ST_MAX,
    ST_MAX_END,
    ST_EMIT_RD,
    ST_EMIT_CHK
  } state_t;

endpackage

// ----- hw/rtl/round_robin_request_dispatcher_unit.sv -----
// A request reads each server's end time in turn, then picks a free server and updates
// its end time and work total; a dropped request skips the update. A report scans all
// work totals for the max, then reads each server's total in turn and emits those equal
// to the max. A new request is taken only in idle, once the last one is through.
// Output stalls hold the FSM.
// Sync active-high reset clears busy/work-valid flags, pointer and FSM; valid bits zero totals.
module round_robin_request_dispatcher_unit #(
  parameter int NUM_SERVERS = rrd_pkg::NUM_SERVERS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rrd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rrd_pkg::rsp_t rsp
);
  import rrd_pkg::*;

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int PTR_W = $clog2(NUM_SERVERS + 1);
  localparam logic [PTR_W-1:0] LAST_CNT = PTR_W'(NUM_SERVERS - 1);

  state_t state, state_next;

  logic [PTR_W-1:0]       cnt;
  logic [IDX_W-1:0]       cnt_idx;
  logic [TIME_W-1:0]      arr;
  logic [TIME_W-1:0]      dur;
  logic [NUM_SERVERS-1:0] busy;
  logic [NUM_SERVERS-1:0] work_vld;
  logic [PTR_W-1:0]       ptr;

  // state memories
  logic [END_W-1:0]  end_mem  [NUM_SERVERS];
  logic [WORK_W-1:0] work_mem [NUM_SERVERS];

  logic [END_W-1:0]  end_q;
  logic [WORK_W-1:0] work_q;
  logic              work_vld_q;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [WORK_W-1:0] work_eff;

  logic [WORK_W-1:0] mx;
  logic [IDX_W-1:0]  mx_idx;
  logic [IDX_W-1:0]  pick;

  // pick search
  logic [NUM_SERVERS-1:0] free_v;
  logic [NUM_SERVERS-1:0] cand_v;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       cand_idx;
  logic [IDX_W-1:0]       pick_next;
  logic                   any_free;

  // control
  logic       slot_free;
  logic       scan_issue;
  logic       pick_issue;
  logic       assign_emit;
  logic       emit_step;
  logic       match;
  logic       rsp_load;
  rsp_t       rsp_next;
  logic [IDX_W-1:0]  work_addr;
  logic [WORK_W:0]   work_sum;
  logic [WORK_W-1:0] work_new;
  logic [END_W-1:0]  end_new;
  logic [END_W-1:0]  arr_plus1;

  assign cnt_idx   = cnt[IDX_W-1:0];
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign work_eff  = work_vld_q ? work_q : '0;
  assign match     = (work_eff == mx);

  assign work_sum  = {1'b0, work_eff} + (WORK_W + 1)'(dur);
  assign work_new  = work_sum[WORK_W] ? '1 : work_sum[WORK_W-1:0];
  assign end_new   = END_W'(arr) + END_W'(dur);
  assign arr_plus1 = END_W'(arr) + END_W'(1);

  // lowest free server at or above the pointer, else lowest free overall
  always_comb begin
    free_v   = ~busy;
    cand_v   = '0;
    free_idx = '0;
    cand_idx = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      cand_v[i] = free_v[i] && (PTR_W'(i) >= ptr);
    end
    for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        free_idx = IDX_W'(i);
      end
      if (cand_v[i]) begin
        cand_idx = IDX_W'(i);
      end
    end
    any_free  = |free_v;
    pick_next = (|cand_v) ? cand_idx : free_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.operation == OP_REPORT) ? ST_MAX : ST_FREE;
        end
      end
      ST_FREE: begin
        if (cnt == LAST_CNT) begin
          state_next = ST_FREE_END;
        end
      end
      ST_FREE_END: state_next = ST_PICK;
      ST_PICK: begin
        if (any_free) begin
          state_next = ST_UPDATE;
        end else if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MAX: begin
        if (cnt == LAST_CNT) begin
          state_next = ST_MAX_END;
        end
      end
      ST_MAX_END: state_next = ST_EMIT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        if (emit_step) begin
          state_next = (cnt == LAST_CNT) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    scan_issue  = 1'b0;
    pick_issue  = 1'b0;
    assign_emit = 1'b0;
    emit_step   = 1'b0;
    rsp_load    = 1'b0;
    rsp_next    = '{kind: KIND_DROPPED, server_id: '0, work_amount: '0, last: 1'b1};
    unique case (state) inside
      ST_FREE, ST_MAX, ST_EMIT_RD: scan_issue = 1'b1;
      ST_PICK: begin
        pick_issue = any_free;
        rsp_load   = !any_free && slot_free;
      end
      ST_UPDATE: begin
        assign_emit = slot_free;
        rsp_load    = slot_free;
        rsp_next    = '{kind: KIND_ASSIGNED, server_id: ID_W'(pick),
                        work_amount: '0, last: 1'b1};
      end
      ST_EMIT_CHK: begin
        emit_step = !match || slot_free;
        rsp_load  = match && slot_free;
        rsp_next  = '{kind: KIND_REPORT, server_id: ID_W'(cnt_idx),
                      work_amount: work_eff, last: (cnt_idx == mx_idx)};
      end
      default: ;
    endcase
  end

  assign work_addr = pick_issue ? pick_next : cnt_idx;

  // end-time memory (holds arrival + duration)
  always_ff @(posedge clk) begin
    if (assign_emit) begin
      end_mem[pick] <= end_new;
    end
    if (scan_issue) begin
      end_q <= end_mem[cnt_idx];
    end
  end

  // work-total memory
  always_ff @(posedge clk) begin
    if (assign_emit) begin
      work_mem[pick] <= work_new;
    end
    if (scan_issue || pick_issue) begin
      work_q <= work_mem[work_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      busy       <= '0;
      work_vld   <= '0;
      ptr        <= '0;
      rd_vld     <= 1'b0;
      work_vld_q <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_issue;
      if (scan_issue || pick_issue) begin
        work_vld_q <= work_vld[work_addr];
      end

      unique case (state) inside
        ST_IDLE:                  cnt <= '0;
        ST_FREE, ST_MAX:          cnt <= cnt + PTR_W'(1);
        ST_MAX_END:               cnt <= '0;
        ST_EMIT_CHK: begin
          if (emit_step) begin
            cnt <= cnt + PTR_W'(1);
          end
        end
        default: ;
      endcase

      // expiry: end time (stored value minus one) at or before arrival
      if (rd_vld && (state == ST_FREE || state == ST_FREE_END)) begin
        if (busy[rd_idx] && end_q <= arr_plus1) begin
          busy[rd_idx] <= 1'b0;
        end
      end

      if (assign_emit) begin
        busy[pick]     <= 1'b1;
        work_vld[pick] <= 1'b1;
        ptr            <= PTR_W'(pick) + PTR_W'(1);
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt_idx;
    if (req_valid && req_ready) begin
      arr    <= req.arrival_time;
      dur    <= req.duration;
      mx     <= '0;
      mx_idx <= '0;
    end
    // ties move the index up, so mx_idx ends on the highest busiest server
    if (rd_vld && (state == ST_MAX || state == ST_MAX_END) && work_eff >= mx) begin
      mx     <= work_eff;
      mx_idx <= rd_idx;
    end
    if (pick_issue) begin
      pick <= pick_next;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- tb/rrd_dispatch_checker.sv -----
`timescale 1ns / 100ps
// rrd_dispatch_checker: watches both transfer channels of the dispatcher, predicts
// every result from its own copy of the server pool and compares in order.
// Depends on rrd_pkg for the payload structs and codes.
module rrd_dispatch_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  rrd_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  rrd_pkg::rsp_t rsp,
  output int            mismatch_count,
  output int            pending_count,
  output int            assigned_count,
  output int            dropped_count,
  output int            report_count,
  output int            busiest_count
);
  import rrd_pkg::*;

  localparam int NSRV = NUM_SERVERS_DEF;
  localparam logic [WORK_W-1:0] WORK_CEIL = '1;

  logic [NSRV-1:0]   srv_busy;
  logic [END_W-1:0]  srv_end  [NSRV];
  logic [WORK_W-1:0] srv_work [NSRV];
  int                rr_ptr;
  rsp_t              expected_rsp_q [$];

  task automatic clear_pool();
    srv_busy = '0;
    for (int i = 0; i < NSRV; i++) begin
      srv_end[i]  = '0;
      srv_work[i] = '0;
    end
    rr_ptr = 0;
  endtask

  task automatic predict_dispatch(input req_t item);
    rsp_t              r;
    logic [WORK_W-1:0] top_work;
    logic [END_W-1:0]  arr_next;
    logic [WORK_W:0]   sum;
    int                pick;
    int                last_id;
    r = '0;
    if (item.operation == OP_REPORT) begin
      top_work = '0;
      last_id  = 0;
      for (int i = 0; i < NSRV; i++)
        if (srv_work[i] > top_work) top_work = srv_work[i];
      for (int i = 0; i < NSRV; i++)
        if (srv_work[i] == top_work) last_id = i;
      for (int i = 0; i < NSRV; i++) begin
        if (srv_work[i] == top_work) begin
          r.kind        = KIND_REPORT;
          r.server_id   = i[ID_W-1:0];
          r.work_amount = srv_work[i];
          r.last        = (i == last_id);
          expected_rsp_q.push_back(r);
          busiest_count++;
        end
      end
      report_count++;
    end else begin
      // a server is done once its end time (start + duration - 1) <= arrival
      arr_next = {1'b0, item.arrival_time} + 1'b1;
      for (int i = 0; i < NSRV; i++)
        if (srv_busy[i] && srv_end[i] <= arr_next) srv_busy[i] = 1'b0;
      pick = -1;
      for (int i = 0; i < NSRV; i++)
        if (pick < 0 && !srv_busy[i] && i >= rr_ptr) pick = i;
      for (int i = 0; i < NSRV; i++)
        if (pick < 0 && !srv_busy[i]) pick = i;
      r.last = 1'b1;
      if (pick < 0) begin
        r.kind = KIND_DROPPED;
        dropped_count++;
      end else begin
        rr_ptr         = pick + 1;
        srv_busy[pick] = 1'b1;
        srv_end[pick]  = {1'b0, item.arrival_time} + {1'b0, item.duration};
        sum            = {1'b0, srv_work[pick]} + item.duration;
        srv_work[pick] = sum[WORK_W] ? WORK_CEIL : sum[WORK_W-1:0];
        r.kind         = KIND_ASSIGNED;
        r.server_id    = pick[ID_W-1:0];
        assigned_count++;
      end
      expected_rsp_q.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp k=%0d id=%0d w=%0h l=%0b, got k=%0d id=%0d w=%0h l=%0b",
               $time, what, want.kind, want.server_id, want.work_amount, want.last,
               got.kind, got.server_id, got.work_amount, got.last);
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    assigned_count = 0;
    dropped_count  = 0;
    report_count   = 0;
    busiest_count  = 0;
    clear_pool();
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_pool();
      expected_rsp_q.delete();
    end else begin
      if (req_valid && req_ready) predict_dispatch(req);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          note_mismatch("unexpected result", '0, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.kind !== want.kind || rsp.server_id !== want.server_id ||
              rsp.work_amount !== want.work_amount || rsp.last !== want.last)
            note_mismatch("result mismatch", want, rsp);
        end
      end
    end
    pending_count = expected_rsp_q.size();
  end

endmodule

// ----- tb/tb_round_robin_request_dispatcher_unit.sv -----
`timescale 1ns / 100ps
// tb_round_robin_request_dispatcher_unit: stimulus and verdict for the dispatcher.
// Instantiates round_robin_request_dispatcher_unit and rrd_dispatch_checker; uses rrd_pkg.
module tb_round_robin_request_dispatcher_unit;
  import rrd_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 70;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int mismatch_count;
  int pending_count;
  int assigned_count;
  int dropped_count;
  int report_count;
  int busiest_count;

  int items_sent;
  bit calm;
  bit hold_rsp;

  round_robin_request_dispatcher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  rrd_dispatch_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .assigned_count (assigned_count),
    .dropped_count  (dropped_count),
    .report_count   (report_count),
    .busiest_count  (busiest_count)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
  end

  always #6 clk = ~clk;

  task automatic offer(input op_t op, input logic [TIME_W-1:0] arr,
                       input logic [TIME_W-1:0] dur);
    req_t item;
    item.operation    = op;
    item.arrival_time = arr;
    item.duration     = dur;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp) begin
        hold_rsp  = 1'b0;
        held      = 0;
        rsp_ready <= 1'b0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [TIME_W-1:0] now;
    logic [TIME_W:0]   room;
    logic [TIME_W-1:0] dur;
    int                day_len;
    int                roll;
    int                rand_start;
    items_sent = 0;
    calm       = 1'b0;
    hold_rsp   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: all-zero report lists every server
    offer(OP_REPORT, $urandom, $urandom);
    offer(OP_REQUEST, 32'd0, 32'd0);              // zero duration on server 0
    offer(OP_REQUEST, 32'd0, 32'd5);              // zero-length job already done
    offer(OP_REQUEST, 32'd1, 32'hFFFF_FFFF);      // longest job that still ends
    offer(OP_REQUEST, 32'd6, 32'd0);
    repeat (15) offer(OP_REQUEST, 32'd10, 32'hFFFF_0000);  // fill the pool
    offer(OP_REQUEST, 32'd20, 32'd3);             // no server free: dropped
    offer(OP_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_REQUEST, 32'hFFFF_FFFF, 32'd0);      // latest arrival frees the pool
    offer(OP_REQUEST, 32'hFFFF_FFFF, 32'd1);

    // random days: mostly ordered arrivals, some going backwards
    rand_start = items_sent;
    hold_rsp   = 1'b1;
    while (items_sent - rand_start < RAND_ITEMS) begin
      now     = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000);
      day_len = $urandom_range(6, 14);
      repeat (day_len) begin
        if (items_sent - rand_start > RAND_ITEMS - 20) calm = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          offer(OP_REPORT, $urandom, $urandom);
        end else if (roll < 14) begin
          offer(OP_REQUEST, $urandom_range(0, now), $urandom_range(0, 40));
        end else begin
          if (now < 32'hFFFF_FF00) now = now + $urandom_range(0, 24);
          // the widest draw is capped so start + duration stays within 2^32 and a late arrival can free it
          room = 33'h1_0000_0000 - {1'b0, now};
          roll = $urandom_range(0, 99);
          if (roll < 25) dur = $urandom_range(0, 3);
          else if (roll < 60) dur = $urandom_range(0, 60);
          else if (roll < 80) dur = $urandom_range(60, 400);
          else if (room[TIME_W]) dur = $urandom;
          else dur = $urandom_range(0, room[TIME_W-1:0]);
          offer(OP_REQUEST, now, dur);
        end
      end
      offer(OP_REPORT, $urandom, $urandom);
      offer(OP_REQUEST, 32'hFFFF_FFFF, $urandom_range(0, 1));
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d items: %0d assigned, %0d dropped, %0d reports (%0d busiest entries)",
             items_sent, assigned_count, dropped_count, report_count, busiest_count);
    $display("Mismatches: %0d, results still outstanding: %0d", mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rrd_pkg.sv
hw/rtl/round_robin_request_dispatcher_unit.sv
tb/rrd_dispatch_checker.sv
tb/tb_round_robin_request_dispatcher_unit.sv
